>>> rtl/core/smsd_pkg.sv
// Shared widths, constants and the run record type for the mean and deviation block.
package smsd_pkg;

    localparam int SMP_W           = 16;   // Q8.8 sample
    localparam int CNT_W           = 11;   // sample count, holds up to 1024
    localparam int SUM_W           = 26;   // signed running sum
    localparam int SQ_W            = 41;   // running sum of squares
    localparam int PROD_W          = 52;   // n*S2 and S1^2 products
    localparam int DIVS_W          = 22;   // n*(n-1) divisor
    localparam int RES_W           = 16;   // mean and std_dev width
    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int Q_DEPTH         = 2;    // finished runs waiting for the back end

    // One finished run, handed from the accumulator to the result engine
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq_sum;
        logic                    dropped;
    } run_t;

endpackage

>>> rtl/core/sample_mean_and_std_dev.sv
// Top level: run statistics (mean and sample standard deviation) over Q8.8 samples.
//
// Input channel (in_valid/in_ready): one beat per item carrying sample, has_sample and
// last. A beat with has_sample adds the sample to the run; beyond MAX_SAMPLES samples it
// is ignored and the run is marked dropped. A beat with last closes the run.
// Output channel (out_valid/out_ready): one beat per closed run with mean, std_dev,
// count and dropped.
// Throughput: the accumulator takes one beat per cycle unless in_ready is low. Each
// closed run goes into a two-entry queue; the back end handles one run at a time,
// using the shift-add multiplier, the one-bit-per-cycle divider (used twice) and the
// square-root loop. in_ready drops only while the queue holds two unfinished runs.
// Path: a closed run is written into the queue, taken by the back end when it is idle,
// and passes through the products, both divisions and the square root to out_valid.
// Stall: a result waits in the output register while out_ready is low; the back end
// finishes the next run meanwhile and holds it until the register frees.
// Reset: clears the accumulators, queue, sequencer and output valid; no sweep needed.
module sample_mean_and_std_dev
    import smsd_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [SMP_W-1:0] sample,
    input  logic                    has_sample,
    input  logic                    last,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [RES_W-1:0] mean,
    output logic [RES_W-1:0]        std_dev,
    output logic [CNT_W-1:0]        count,
    output logic                    dropped
);

    logic q_full;
    logic q_push;
    run_t q_push_data;
    logic q_pop;
    logic q_valid;
    run_t q_pop_data;

    smsd_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .has_sample (has_sample),
        .last       (last),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_push_data)
    );

    smsd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_pop_data)
    );

    smsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .mean      (mean),
        .std_dev   (std_dev),
        .count     (count),
        .dropped   (dropped)
    );

endmodule

>>> rtl/core/smsd_front.sv
// Front end: accepts sample beats and accumulates count, sum and sum of squares.
module smsd_front
    import smsd_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [SMP_W-1:0] sample,
    input  logic                    has_sample,
    input  logic                    last,
    input  logic                    q_full,
    output logic                    q_push,
    output run_t                    q_data
);

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic                    ovf_reg, ovf_next;
    logic signed [2*SMP_W-1:0] smp_sq;
    logic                    accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign smp_sq   = sample * sample;

    // Take the sample first, then form the record on an end-of-run beat
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        sq_next    = sq_reg;
        ovf_next   = ovf_reg;
        if (has_sample)
        begin
            if (count_reg < CNT_W'(MAX_SAMPLES))
            begin
                count_next = count_reg + CNT_W'(1);
                sum_next   = sum_reg + SUM_W'(sample);
                sq_next    = sq_reg + SQ_W'($unsigned(smp_sq));
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    assign q_push         = accept && last;
    assign q_data.count   = count_next;
    assign q_data.sum     = sum_next;
    assign q_data.sq_sum  = sq_next;
    assign q_data.dropped = ovf_next;

    // Accumulators, cleared after each run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                sq_reg    <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                sq_reg    <= sq_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

`ifndef SYNTH
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count above capacity");
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> count_reg == '0 && !ovf_reg)
        else $error("accumulators not cleared after run end");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("run pushed into a full queue");
`endif

endmodule

>>> rtl/core/smsd_fifo.sv
// Short queue of finished run records between the front and back ends.
module smsd_fifo
    import smsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  run_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output run_t pop_data
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int LVL_W = $clog2(Q_DEPTH + 1);

    run_t             mem [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;

    assign full      = level_reg == LVL_W'(Q_DEPTH);
    assign not_empty = level_reg != '0;
    assign pop_data  = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + LVL_W'(1);
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - LVL_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue overrun");
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue underrun");
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_W'(Q_DEPTH))
        else $error("queue level out of range");
`endif

endmodule

>>> rtl/core/smsd_div.sv
// Restoring divider, one quotient bit per cycle, shared by the mean and variance.
module smsd_div
    import smsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [PROD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(PROD_W);

    logic [PROD_W-1:0] dvd_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVS_W:0]   rem_sh;
    logic [DIVS_W:0]   diff;
    logic              ge;

    // One trial subtract per cycle; quotient bits shift into the dividend register
    assign rem_sh = {rem_reg, dvd_reg[PROD_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[PROD_W-2:0], ge};
            rem_reg <= ge ? diff[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(PROD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && dvs_reg != '0 |-> rem_reg < dvs_reg)
        else $error("partial remainder not below divisor");
`endif

endmodule

>>> rtl/core/smsd_back.sv
// Back end: per-run products, divisions and square root, plus the result register.
module smsd_back
    import smsd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  run_t                    q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [RES_W-1:0] mean,
    output logic [RES_W-1:0]        std_dev,
    output logic [CNT_W-1:0]        count,
    output logic                    dropped
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MULA = 3'd1;
    localparam logic [2:0] ST_MULB = 3'd2;
    localparam logic [2:0] ST_DIVM = 3'd3;
    localparam logic [2:0] ST_DIVV = 3'd4;
    localparam logic [2:0] ST_SQRT = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam int SQRT_TOP = ((PROD_W - 1) / 2) * 2;
    localparam logic [PROD_W-1:0] SQRT_START = PROD_W'(1) << SQRT_TOP;

    logic [2:0]        state_reg;
    run_t              rec_reg;
    logic [SUM_W-1:0]  mag_reg;
    logic [PROD_W-1:0] mcand_reg;
    logic [SUM_W-1:0]  mplier_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] prod_a_reg;
    logic [PROD_W-1:0] num_reg;
    logic [SUM_W-1:0]  mq_reg;
    logic [PROD_W-1:0] sq_v_reg;
    logic [PROD_W-1:0] root_reg;
    logic [PROD_W-1:0] bit_reg;

    logic                    out_valid_reg;
    logic signed [RES_W-1:0] mean_reg;
    logic [RES_W-1:0]        std_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    dropped_reg;

    logic              div_start;
    logic [PROD_W-1:0] div_dvd;
    logic [DIVS_W-1:0] div_dvs;
    logic              div_done;
    logic [PROD_W-1:0] div_q;

    logic [SUM_W-1:0]  q_mag;
    logic [DIVS_W-1:0] den;
    logic [PROD_W-1:0] trial;
    logic              slot_free;
    logic [SUM_W-1:0]  mean_full;

    smsd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // Magnitude of the incoming sum; n*(n-1) from the held record
    assign q_mag = q_data.sum[SUM_W-1] ? (~q_data.sum + SUM_W'(1)) : q_data.sum;
    assign den   = DIVS_W'(rec_reg.count) * (DIVS_W'(rec_reg.count) - DIVS_W'(1));
    assign trial = root_reg + bit_reg;

    assign slot_free = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    // Divider launches: mean right after the products, variance after the mean
    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = {{(PROD_W-SUM_W){1'b0}}, mag_reg};
        div_dvs   = DIVS_W'(rec_reg.count);
        if (state_reg == ST_MULB && mplier_reg == '0)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == ST_DIVM && div_done)
        begin
            div_start = 1'b1;
            div_dvd   = num_reg;
            div_dvs   = den;
        end
    end

    assign mean_full = rec_reg.sum[SUM_W-1] ? (~mq_reg + SUM_W'(1)) : mq_reg;

    // Sequencer and datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    rec_reg    <= q_data;
                    mag_reg    <= q_mag;
                    mcand_reg  <= PROD_W'(q_data.sq_sum);
                    mplier_reg <= SUM_W'(q_data.count);
                    acc_reg    <= '0;
                end
            end
            ST_MULA:
            begin
                if (mplier_reg == '0)
                begin
                    prod_a_reg <= acc_reg;
                    mcand_reg  <= PROD_W'(mag_reg);
                    mplier_reg <= mag_reg;
                    acc_reg    <= '0;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end
            end
            ST_MULB:
            begin
                if (mplier_reg == '0)
                begin
                    num_reg <= (prod_a_reg > acc_reg) ? prod_a_reg - acc_reg : '0;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end
            end
            ST_DIVM:
            begin
                if (div_done)
                begin
                    mq_reg <= div_q[SUM_W-1:0];
                end
            end
            ST_DIVV:
            begin
                if (div_done)
                begin
                    sq_v_reg <= div_q;
                    root_reg <= '0;
                    bit_reg  <= SQRT_START;
                end
            end
            ST_SQRT:
            begin
                if (bit_reg != '0)
                begin
                    if (sq_v_reg >= trial)
                    begin
                        sq_v_reg <= sq_v_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result register, loaded once the output slot is free
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && slot_free)
        begin
            count_reg   <= rec_reg.count;
            dropped_reg <= rec_reg.dropped;
            mean_reg    <= (rec_reg.count == '0) ? '0 : RES_W'(mean_full);
            if (rec_reg.count < CNT_W'(2))
            begin
                std_reg <= '0;
            end
            else if (root_reg > PROD_W'({RES_W{1'b1}}))
            begin
                std_reg <= '1;
            end
            else
            begin
                std_reg <= root_reg[RES_W-1:0];
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: if (q_valid) state_reg <= ST_MULA;
                ST_MULA: if (mplier_reg == '0) state_reg <= ST_MULB;
                ST_MULB: if (mplier_reg == '0) state_reg <= ST_DIVM;
                ST_DIVM: if (div_done) state_reg <= ST_DIVV;
                ST_DIVV: if (div_done) state_reg <= ST_SQRT;
                ST_SQRT: if (bit_reg == '0) state_reg <= ST_DONE;
                ST_DONE: if (slot_free) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign mean      = mean_reg;
    assign std_dev   = std_reg;
    assign count     = count_reg;
    assign dropped   = dropped_reg;

`ifndef SYNTH
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVM || state_reg == ST_DIVV)
        else $error("divider finished outside a division step");
    a_short_run_sd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && count_reg < CNT_W'(2) |-> std_reg == '0)
        else $error("nonzero deviation for fewer than two samples");
    a_empty_mean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && count_reg == '0 |-> mean_reg == '0)
        else $error("nonzero mean for an empty run");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == ST_MULA)
        else $error("run taken but sequencer did not start");
`endif

endmodule

>>> tb/smsd_stats_checker.sv
// Watches both channels of the run statistics block and checks every result beat.
`timescale 1ns / 1ps

module smsd_stats_checker
    import smsd_pkg::*;
#(
    parameter int CAPACITY = MAX_SAMPLES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic signed [SMP_W-1:0] sample,
    input  logic                    has_sample,
    input  logic                    last,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic signed [RES_W-1:0] mean,
    input  logic [RES_W-1:0]        std_dev,
    input  logic [CNT_W-1:0]        count,
    input  logic                    dropped,
    output int                      mismatches,
    output int                      waiting
);

    typedef longint unsigned u64_t;

    typedef struct {
        logic signed [RES_W-1:0] mean;
        logic [RES_W-1:0]        std_dev;
        logic [CNT_W-1:0]        count;
        logic                    dropped;
    } run_stats_t;

    // Shadow accumulators of the current run
    logic [CNT_W-1:0]        run_n;
    logic signed [SUM_W-1:0] run_sum;
    logic [SQ_W-1:0]         run_sq;
    logic                    run_over;

    run_stats_t stats_q[$];

    // floor(sqrt(v)), one result bit per step from the top
    function automatic u64_t floor_sqrt(input u64_t v);
        u64_t root;
        u64_t trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (u64_t'(1) << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Mean and Bessel-corrected deviation of the run held in the shadow state
    function automatic run_stats_t close_run();
        run_stats_t      r;
        longint          sum_l;
        u64_t            nn;
        u64_t            mag;
        u64_t            lhs;
        u64_t            rhs;
        u64_t            num;
        u64_t            root;
        longint          avg;
        sum_l = longint'(run_sum);
        nn    = u64_t'(run_n);
        avg   = 0;
        root  = 0;
        if (run_n != 0)
            avg = sum_l / longint'(nn);
        if (run_n >= 2)
        begin
            mag  = (sum_l < 0) ? u64_t'(-sum_l) : u64_t'(sum_l);
            lhs  = nn * u64_t'(run_sq);
            rhs  = mag * mag;
            num  = (lhs > rhs) ? lhs - rhs : 0;
            root = floor_sqrt(num / (nn * (nn - 1)));
            if (root > 65535)
                root = 65535;
        end
        r.mean    = avg[RES_W-1:0];
        r.std_dev = root[RES_W-1:0];
        r.count   = run_n;
        r.dropped = run_over;
        return r;
    endfunction

    task automatic flag(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    always @(posedge clk)
    begin
        longint     sq_term;
        run_stats_t want;
        if (!rst_n)
        begin
            run_n    = '0;
            run_sum  = '0;
            run_sq   = '0;
            run_over = 1'b0;
            stats_q.delete();
        end
        else
        begin
            // Input beat: accumulate, close the run on last
            if (in_valid && in_ready)
            begin
                if (has_sample)
                begin
                    if (run_n < CAPACITY)
                    begin
                        sq_term = longint'(sample) * longint'(sample);
                        run_n   = run_n + 1'b1;
                        run_sum = run_sum + sample;
                        run_sq  = run_sq + sq_term[SQ_W-1:0];
                    end
                    else
                        run_over = 1'b1;
                end
                if (last)
                begin
                    stats_q.push_back(close_run());
                    run_n    = '0;
                    run_sum  = '0;
                    run_sq   = '0;
                    run_over = 1'b0;
                end
            end

            // Result beat: compare with the oldest closed run
            if (out_valid && out_ready)
            begin
                if (stats_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with no run closed (mean %0d count %0d)",
                                 $realtime, mean, count);
                end
                else
                begin
                    want = stats_q.pop_front();
                    if (mean !== want.mean)
                        flag("mean", want.mean, mean);
                    if (std_dev !== want.std_dev)
                        flag("std_dev", want.std_dev, std_dev);
                    if (count !== want.count)
                        flag("count", want.count, count);
                    if (dropped !== want.dropped)
                        flag("dropped", want.dropped, dropped);
                end
            end
        end
        waiting = stats_q.size();
    end

endmodule

>>> tb/tb_sample_mean_and_std_dev.sv
// Top of the run statistics testbench: clock, reset, beat stimulus and the verdict.
`timescale 1ns / 1ps

module tb_sample_mean_and_std_dev;
    import smsd_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 200;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [SMP_W-1:0] sample;
    logic                    has_sample;
    logic                    last;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [RES_W-1:0] mean;
    logic [RES_W-1:0]        std_dev;
    logic [CNT_W-1:0]        count;
    logic                    dropped;

    int mismatches;
    int waiting;
    int cycles;
    int beats_sent;
    bit calm;   // no idling on either side while set

    sample_mean_and_std_dev dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .has_sample (has_sample),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mean       (mean),
        .std_dev    (std_dev),
        .count      (count),
        .dropped    (dropped)
    );

    smsd_stats_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .has_sample (has_sample),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mean       (mean),
        .std_dev    (std_dev),
        .count      (count),
        .dropped    (dropped),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Watchdog
    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random back-pressure
    initial
    begin
        out_ready = 1'b0;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(0, 99) >= 16);
    end

    // One input beat, with random idle cycles ahead of it; returns at the falling edge
    task automatic send_beat(input logic signed [SMP_W-1:0] s, input logic h, input logic l);
        while (!calm && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        sample     <= s;
        has_sample <= h;
        last       <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (h || l)
            beats_sent++;
        @(negedge clk);
    endtask

    function automatic logic signed [SMP_W-1:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2, 3:    return SMP_W'($signed($urandom_range(0, 64)) - 32);
            default: return r[SMP_W-1:0];
        endcase
    endfunction

    // A run of random length, with occasional empty beats mixed in
    task automatic send_run();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_beat(pick_sample(), 1'b0, 1'b0);
            send_beat(pick_sample(), 1'b1, 1'b0);
        end
        send_beat(pick_sample(), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        sample     = '0;
        has_sample = 1'b0;
        last       = 1'b0;
        calm       = 1'b0;
        beats_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty run, then single-sample runs at both extremes
        send_beat(16'sd0, 1'b0, 1'b1);
        send_beat(16'sd32767, 1'b1, 1'b1);
        send_beat(-16'sd32768, 1'b1, 1'b1);
        // Widest spread, then a negative mean that truncates toward zero
        send_beat(-16'sd32768, 1'b1, 1'b0);
        send_beat(16'sd32767, 1'b1, 1'b1);
        send_beat(-16'sd3, 1'b1, 1'b0);
        send_beat(16'sd1234, 1'b0, 1'b0);
        send_beat(-16'sd4, 1'b1, 1'b1);
        // One sample, then a bare end marker
        send_beat(16'sd77, 1'b1, 1'b0);
        send_beat(-16'sd1, 1'b0, 1'b1);
        send_beat(16'sd5, 1'b1, 1'b0);
        send_beat(16'sd6, 1'b1, 1'b0);
        send_beat(-16'sd100, 1'b1, 1'b1);

        // Full capacity of alternating extremes, an overflow beat, an empty beat,
        // then a sample on last that is dropped
        for (int i = 0; i < MAX_SAMPLES_DEF; i++)
            send_beat((i % 2) ? 16'sd32767 : -16'sd32768, 1'b1, 1'b0);
        send_beat(16'sd100, 1'b1, 1'b0);
        send_beat(16'sd9, 1'b0, 1'b0);
        send_beat(-16'sd5, 1'b1, 1'b1);

        // Random runs, with a quiet stretch in the middle
        beats_sent = 0;
        while (beats_sent < RANDOM_ITEMS)
        begin
            calm = (beats_sent >= 150 && beats_sent < 300);
            send_run();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // Drain, then let the back end settle
        while (waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
